// ===== design/bba_pkg.sv =====
package bba_pkg;

  localparam int unsigned BLOCK_W        = 13;
  localparam int unsigned DISK_W         = 14;
  localparam int unsigned MAX_BLOCKS_DEF = 8192;
  localparam int unsigned WORD_BITS_DEF  = 32;
  localparam logic [DISK_W-1:0] DISK_RESET = DISK_W'(8192);

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_FULL        = 2'd1,
    ST_DOUBLE_FREE = 2'd2,
    ST_RANGE       = 2'd3
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FREE_RD,
    S_FREE_CHK,
    S_ALLOC_RD,
    S_SCAN,
    S_DONE
  } state_e;

  // one queued request, word index is an estimate that may be one low
  typedef struct packed {
    op_e                op;
    logic [BLOCK_W-1:0] blk;
    logic [BLOCK_W-1:0] word_est;
    logic               range_err;
  } entry_t;

  typedef struct packed {
    logic   not_empty;
    entry_t head;
  } q_status_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } bk_ctrl_t;

  // width that holds block counts, covered size and a sign bit
  // the padded bitmap capacity always stays below max_blocks + word_bits
  function automatic int unsigned len_width(int unsigned max_blocks, int unsigned word_bits);
    int unsigned base_w;
    base_w = $clog2(max_blocks + word_bits);
    return ((base_w > DISK_W) ? base_w : DISK_W) + 1;
  endfunction

endpackage

// ===== design/block_bitmap_allocator.sv =====
// free: read the bitmap word, check and clear the bit, then load the result word; a block
// out of range skips the read. alloc: scan from the lowest word that may still hold a free
// block, one bitmap word per cycle over the single ram read port
// a 2-entry request queue lets up to two requests be accepted while one is in work
// reset (async, active low) clears control state, then a clearing pass over every bitmap
// word zeroes the bitmap with the input stalled
module block_bitmap_allocator #(
  parameter int unsigned MaxBlocks = bba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned WordBits  = bba_pkg::WORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bba_pkg::DISK_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        op_i,
  input  logic [bba_pkg::BLOCK_W-1:0] block_number_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bba_pkg::BLOCK_W-1:0] allocated_block_o,
  output logic [1:0]                  status_o
);

  localparam int unsigned LenW = bba_pkg::len_width(MaxBlocks, WordBits);

  logic [bba_pkg::DISK_W-1:0] disk_q;
  logic [LenW-1:0]            size;
  bba_pkg::q_status_t         q_stat;
  bba_pkg::bk_ctrl_t          bk_ctrl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_q <= bba_pkg::DISK_RESET;
    end else if (cfg_we_i) begin
      disk_q <= cfg_wdata_i;
    end
  end

  // covered size saturates at MaxBlocks
  assign size = (LenW'(disk_q) > LenW'(MaxBlocks)) ? LenW'(MaxBlocks) : LenW'(disk_q);

  bba_front #(
    .MaxBlocks(MaxBlocks),
    .WordBits (WordBits)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .block_number_i(block_number_i),
    .size_i        (size),
    .ctrl_i        (bk_ctrl),
    .q_o           (q_stat)
  );

  bba_back #(
    .MaxBlocks(MaxBlocks),
    .WordBits (WordBits)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .size_i           (size),
    .q_i              (q_stat),
    .ctrl_o           (bk_ctrl),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .allocated_block_o(allocated_block_o),
    .status_o         (status_o)
  );

endmodule

// ===== design/bba_ram.sv =====
module bba_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/bba_front.sv =====
module bba_front #(
  parameter int unsigned MaxBlocks = bba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned WordBits  = bba_pkg::WORD_BITS_DEF
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             in_valid_i,
  output logic                                             in_stall_o,
  input  logic                                             op_i,
  input  logic [bba_pkg::BLOCK_W-1:0]                      block_number_i,
  input  logic [bba_pkg::len_width(MaxBlocks, WordBits)-1:0] size_i,
  input  bba_pkg::bk_ctrl_t                                ctrl_i,
  output bba_pkg::q_status_t                               q_o
);

  localparam int unsigned BW   = bba_pkg::BLOCK_W;
  localparam int unsigned LenW = bba_pkg::len_width(MaxBlocks, WordBits);
  // reciprocal of the word size, estimate is exact or one low
  localparam logic [BW-1:0] RecipC = BW'((1 << BW) / WordBits);

  bba_pkg::entry_t ent_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q;
  logic            push, pop;
  logic [2*BW-1:0] prod;
  bba_pkg::entry_t new_ent;

  assign in_stall_o = (cnt_q == 2'd2) || ctrl_i.clearing;
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = ctrl_i.pop && (cnt_q != 2'd0);

  always_comb begin
    prod              = (2*BW)'(block_number_i) * (2*BW)'(RecipC);
    new_ent.op        = bba_pkg::op_e'(op_i);
    new_ent.blk       = block_number_i;
    new_ent.word_est  = prod[2*BW-1:BW];
    new_ent.range_err = LenW'(block_number_i) >= size_i;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= new_ent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  assign q_o.not_empty = cnt_q != 2'd0;
  assign q_o.head      = ent_q[rd_ptr_q];

endmodule

// ===== design/bba_back.sv =====
module bba_back #(
  parameter int unsigned MaxBlocks = bba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned WordBits  = bba_pkg::WORD_BITS_DEF
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic [bba_pkg::len_width(MaxBlocks, WordBits)-1:0] size_i,
  input  bba_pkg::q_status_t                               q_i,
  output bba_pkg::bk_ctrl_t                                ctrl_o,
  output logic                                             out_valid_o,
  input  logic                                             out_stall_i,
  output logic [bba_pkg::BLOCK_W-1:0]                      allocated_block_o,
  output logic [1:0]                                       status_o
);

  localparam int unsigned BW       = bba_pkg::BLOCK_W;
  localparam int unsigned LenW     = bba_pkg::len_width(MaxBlocks, WordBits);
  localparam int unsigned MapWords = (MaxBlocks + WordBits - 1) / WordBits;
  localparam int unsigned AW       = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int unsigned KW       = $clog2(WordBits);
  localparam logic [LenW-1:0] WbL  = LenW'(WordBits);

  bba_pkg::state_e  state_q, state_d;
  bba_pkg::entry_t  ent_q, ent_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [AW-1:0]    hint_q, hint_d;
  logic [LenW-1:0]  hint_base_q, hint_base_d;
  logic [AW-1:0]    scan_q, scan_d;
  logic [LenW-1:0]  base_q, base_d;
  logic [BW-1:0]    wword_q, wword_d;
  logic [KW-1:0]    wbit_q, wbit_d;
  logic [LenW-1:0]  wbase_q, wbase_d;
  logic [BW-1:0]    res_blk_q, res_blk_d;
  bba_pkg::status_e res_st_q, res_st_d;
  logic             out_valid_q, out_valid_d;
  logic [BW-1:0]    out_blk_q;
  bba_pkg::status_e out_st_q;
  logic             out_load;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [WordBits-1:0] ram_wdata, rd_data;

  logic [LenW-1:0]        qbase, rmd, got;
  logic signed [LenW-1:0] rem;
  logic [WordBits-1:0]    free_vec;
  logic [KW-1:0]          pick;

  bba_ram #(
    .Width(WordBits),
    .Depth(MapWords)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(rd_data)
  );

  // free bits of the word being scanned that lie below the covered size
  always_comb begin
    rem  = $signed(size_i - base_q);
    pick = '0;
    for (int k = 0; k < WordBits; k++) begin
      free_vec[k] = !rd_data[k] && (rem > $signed(LenW'(k)));
    end
    for (int k = WordBits - 1; k >= 0; k--) begin
      if (free_vec[k]) pick = KW'(k);
    end
    got   = base_q + LenW'(pick);
    qbase = LenW'(ent_q.word_est) * WbL;
    rmd   = LenW'(ent_q.blk) - qbase;
  end

  assign out_load = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    ent_d       = ent_q;
    clr_d       = clr_q;
    hint_d      = hint_q;
    hint_base_d = hint_base_q;
    scan_d      = scan_q;
    base_d      = base_q;
    wword_d     = wword_q;
    wbit_d      = wbit_q;
    wbase_d     = wbase_q;
    res_blk_d   = res_blk_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q && out_stall_i;
    ctrl_o.pop      = 1'b0;
    ctrl_o.clearing = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;

    unique case (state_q)
      bba_pkg::S_CLEAR: begin
        ctrl_o.clearing = 1'b1;
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(MapWords - 1)) state_d = bba_pkg::S_IDLE;
      end
      bba_pkg::S_IDLE: begin
        if (q_i.not_empty) begin
          ctrl_o.pop = 1'b1;
          ent_d      = q_i.head;
          res_blk_d  = '0;
          if (q_i.head.op == bba_pkg::OP_FREE && q_i.head.range_err) begin
            res_st_d = bba_pkg::ST_RANGE;
            state_d  = bba_pkg::S_DONE;
          end else if (q_i.head.op == bba_pkg::OP_FREE) begin
            state_d = bba_pkg::S_FREE_RD;
          end else begin
            state_d = bba_pkg::S_ALLOC_RD;
          end
        end
      end
      bba_pkg::S_FREE_RD: begin
        // correct the word estimate by one if the remainder overflows
        if (rmd >= WbL) begin
          wword_d = ent_q.word_est + BW'(1);
          wbit_d  = KW'(rmd - WbL);
          wbase_d = qbase + WbL;
        end else begin
          wword_d = ent_q.word_est;
          wbit_d  = KW'(rmd);
          wbase_d = qbase;
        end
        ram_re    = 1'b1;
        ram_raddr = wword_d[AW-1:0];
        state_d   = bba_pkg::S_FREE_CHK;
      end
      bba_pkg::S_FREE_CHK: begin
        if (!rd_data[wbit_q]) begin
          res_st_d = bba_pkg::ST_DOUBLE_FREE;
        end else begin
          res_st_d  = bba_pkg::ST_OK;
          ram_we    = 1'b1;
          ram_waddr = wword_q[AW-1:0];
          ram_wdata = rd_data & ~(WordBits'(1) << wbit_q);
          if (wword_q[AW-1:0] < hint_q) begin
            hint_d      = wword_q[AW-1:0];
            hint_base_d = wbase_q;
          end
        end
        state_d = bba_pkg::S_DONE;
      end
      bba_pkg::S_ALLOC_RD: begin
        // every word below the hint is known full
        if ($signed(size_i - hint_base_q) <= $signed(LenW'(0))) begin
          res_st_d = bba_pkg::ST_FULL;
          state_d  = bba_pkg::S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = hint_q;
          scan_d    = hint_q;
          base_d    = hint_base_q;
          state_d   = bba_pkg::S_SCAN;
        end
      end
      bba_pkg::S_SCAN: begin
        if (|free_vec) begin
          ram_we      = 1'b1;
          ram_waddr   = scan_q;
          ram_wdata   = rd_data | (WordBits'(1) << pick);
          hint_d      = scan_q;
          hint_base_d = base_q;
          res_blk_d   = got[BW-1:0];
          res_st_d    = bba_pkg::ST_OK;
          state_d     = bba_pkg::S_DONE;
        end else if (rem <= $signed(WbL)) begin
          res_st_d = bba_pkg::ST_FULL;
          state_d  = bba_pkg::S_DONE;
        end else begin
          scan_d    = scan_q + AW'(1);
          base_d    = base_q + WbL;
          ram_re    = 1'b1;
          ram_raddr = scan_d;
        end
      end
      bba_pkg::S_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = bba_pkg::S_IDLE;
        end
      end
      default: state_d = bba_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bba_pkg::S_CLEAR;
      clr_q       <= '0;
      hint_q      <= '0;
      hint_base_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      hint_q      <= hint_d;
      hint_base_q <= hint_base_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q     <= ent_d;
    scan_q    <= scan_d;
    base_q    <= base_d;
    wword_q   <= wword_d;
    wbit_q    <= wbit_d;
    wbase_q   <= wbase_d;
    res_blk_q <= res_blk_d;
    res_st_q  <= res_st_d;
    if (state_q == bba_pkg::S_DONE && out_load) begin
      out_blk_q <= res_blk_q;
      out_st_q  <= res_st_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign allocated_block_o = out_blk_q;
  assign status_o          = out_st_q;

  a_hint_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hint_base_q == LenW'(hint_q) * WbL)
    else $error("hint base out of step with hint word");

  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bba_pkg::S_CLEAR |-> !ctrl_o.pop)
    else $error("request taken during bitmap clear");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_st_q != bba_pkg::ST_OK |-> out_blk_q == '0)
    else $error("error result carries a block number");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == bba_pkg::S_DONE)
    else $error("result word without a finished request");

endmodule
